FILE: src/bird_pkg.sv
// Shared types and constants of the battery diagnostic response decoder.
// No dependencies; used by every module of the block.
package bird_pkg;

  localparam int CELL_COUNT = 96;
  localparam int ACC_SLOTS  = 14;
  localparam int MAX_RES    = 4;

  localparam logic [7:0] PCI_FIRST  = 8'h10;
  localparam logic [7:0] SID_RESP   = 8'h61;
  localparam logic [7:0] DID_01     = 8'h01;
  localparam logic [7:0] DID_03     = 8'h03;
  localparam logic [7:0] DID_41     = 8'h41;
  localparam logic [7:0] DID_42     = 8'h42;
  localparam logic [7:0] DID_61     = 8'h61;
  localparam logic [7:0] DID_66     = 8'h66;
  localparam logic [7:0] SEQ_WRAP   = 8'h20;
  localparam logic [7:0] SEQ_21     = 8'h21;
  localparam logic [7:0] SEQ_22     = 8'h22;
  localparam logic [7:0] SEQ_23     = 8'h23;
  localparam logic [7:0] SEQ_24     = 8'h24;
  localparam logic [7:0] SEQ_26     = 8'h26;
  localparam logic [7:0] SEQ_27     = 8'h27;
  localparam logic [7:0] SEQ_29     = 8'h29;
  localparam logic [7:0] SEQ_2A     = 8'h2A;
  localparam logic [7:0] SEQ_2F     = 8'h2F;

  // Pack value ids
  localparam logic [6:0] ID_AMP_HOURS = 7'd96;
  localparam logic [6:0] ID_HEALTH    = 7'd97;
  localparam logic [6:0] ID_KM        = 7'd98;
  localparam logic [6:0] ID_QUICK     = 7'd99;
  localparam logic [6:0] ID_NORMAL    = 7'd100;
  localparam logic [6:0] ID_FULL      = 7'd101;
  localparam logic [6:0] ID_PARTIAL   = 7'd102;
  localparam logic [6:0] ID_TEMP      = 7'd103;
  localparam logic [6:0] ID_HIGH_MV   = 7'd104;
  localparam logic [6:0] ID_LOW_MV    = 7'd105;
  localparam logic [6:0] ID_MAX_CHG   = 7'd106;
  localparam logic [6:0] ID_CURRENT   = 7'd107;
  localparam logic [6:0] ID_MAX_IN    = 7'd108;
  localparam logic [6:0] ID_MAX_OUT   = 7'd109;
  localparam logic [6:0] ID_PACK_V    = 7'd110;
  localparam logic [6:0] ID_DIAG_V    = 7'd111;

  // Results of one frame, handed from decoder to output buffer
  typedef struct packed {
    logic [MAX_RES-1:0][6:0]  id;
    logic [MAX_RES-1:0][31:0] word;
    logic [2:0]               cnt;
    logic                     valid;
    logic                     more;
  } res_set_t;

endpackage

FILE: src/bird_dec.sv
// Frame decoder: identifier and sequence state, split-value accumulators,
// and the combinational decode of one frame into up to four results.
// Depends on bird_pkg.
module bird_dec (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [63:0]        frame,
  input  logic               take,
  output bird_pkg::res_set_t res
);
  import bird_pkg::*;

  logic [7:0]  aid_r, aid_nxt;
  logic        wrap_r, wrap_nxt;
  logic [31:0] odo_r, odo_nxt;
  logic [15:0] hc_r, hc_nxt;
  logic [15:0] acc_r [ACC_SLOTS];

  logic [7:0]  b [8];
  logic [7:0]  s;
  logic [4:0]  k;
  logic [6:0]  obase, cbase, gbase;
  logic [3:0]  soff, p, slot;
  logic [15:0] accv, acc_wdata;
  logic        acc_we;
  logic [3:0][15:0] gw;

  function automatic logic [31:0] pr(input logic [7:0] hi, input logic [7:0] lo);
    return {16'h0, hi, lo};
  endfunction

  always_comb begin
    for (int i = 0; i < 8; i++) b[i] = frame[8*i +: 8];
  end
  assign s = b[0];

  // Cell group addressing
  assign p     = k[4:1];
  assign gbase = (k[0] ? cbase : obase) + (7'({3'b0, p} << 3) - 7'({3'b0, p}));
  assign slot  = soff + p;
  assign accv  = acc_r[slot] + {8'h0, b[1]};
  assign acc_wdata = k[0] ? accv : {b[7], 8'h0};

  always_comb begin
    if (k[0]) begin
      gw[0] = accv;
      gw[1] = {b[2], b[3]};
      gw[2] = {b[4], b[5]};
      gw[3] = {b[6], b[7]};
    end else begin
      gw[0] = {b[1], b[2]};
      gw[1] = {b[3], b[4]};
      gw[2] = {b[5], b[6]};
      gw[3] = {b[7], 8'h0};
    end
  end

  // Decode one frame
  always_comb begin
    aid_nxt = (s == PCI_FIRST && b[2] == SID_RESP) ? b[3] : aid_r;
    wrap_nxt = wrap_r;
    odo_nxt  = odo_r;
    hc_nxt   = hc_r;
    k = '0; obase = 7'd2; cbase = 7'd5; soff = 4'd0;
    acc_we = 1'b0;
    res = '0;
    res.cnt = 3'd0;
    for (int i = 0; i < MAX_RES; i++) begin
      res.id[i]   = gbase + 7'(i);
      res.word[i] = {16'h0, gw[i]};
    end
    case (aid_nxt)
      DID_41: begin
        if (s == PCI_FIRST) begin
          wrap_nxt = 1'b0;
          res.id[0] = 7'd0; res.word[0] = pr(b[4], b[5]);
          res.id[1] = 7'd1; res.word[1] = pr(b[6], b[7]);
          res.cnt = 3'd2; res.more = 1'b1;
        end else if ((!wrap_r && (s == SEQ_21 || s == SEQ_22)) ||
                     (s >= SEQ_23 && s <= SEQ_2F)) begin
          k = 5'(s - SEQ_21); acc_we = 1'b1; res.cnt = 3'd4; res.more = 1'b1;
        end else if (s == SEQ_WRAP) begin
          wrap_nxt = 1'b1;
          k = 5'd15; acc_we = 1'b1; res.cnt = 3'd4; res.more = 1'b1;
        end else if (wrap_r && s == SEQ_21) begin
          k = 5'd16; acc_we = 1'b1; res.cnt = 3'd4; res.more = 1'b1;
        end else if (wrap_r && s == SEQ_22) begin
          wrap_nxt = 1'b0;
          k = 5'd17; acc_we = 1'b1; res.cnt = 3'd1;
        end
      end
      DID_42: begin
        obase = 7'd64; cbase = 7'd67; soff = 4'd9;
        if (s == PCI_FIRST) begin
          res.id[0] = 7'd62; res.word[0] = pr(b[4], b[5]);
          res.id[1] = 7'd63; res.word[1] = pr(b[6], b[7]);
          res.cnt = 3'd2; res.more = 1'b1;
        end else if (s >= SEQ_21 && s <= SEQ_29) begin
          k = 5'(s - SEQ_21); acc_we = 1'b1; res.cnt = 3'd4; res.more = 1'b1;
        end else if (s == SEQ_2A) begin
          k = 5'd9; acc_we = 1'b1;
          res.id[1] = ID_PACK_V; res.word[1] = pr(b[2], b[3]);
          res.id[2] = ID_DIAG_V; res.word[2] = pr(b[4], b[5]);
          res.cnt = 3'd3;
        end
      end
      DID_61: begin
        if (s == PCI_FIRST) begin
          res.more = 1'b1;
        end else if (s == SEQ_21) begin
          odo_nxt = {b[6], b[7], 16'h0};
          res.id[0] = ID_AMP_HOURS; res.word[0] = {b[1], b[2], b[3], b[4]};
          res.id[1] = ID_HEALTH;    res.word[1] = {24'h0, b[5]};
          res.id[2] = ID_KM;        res.word[2] = odo_nxt;
          res.cnt = 3'd3; res.more = 1'b1;
        end else if (s == SEQ_22) begin
          odo_nxt = odo_r + {24'h0, b[1]};
          res.id[0] = ID_KM; res.word[0] = odo_nxt;
          res.cnt = 3'd1;
        end
      end
      DID_66: begin
        if (s == PCI_FIRST) begin
          res.id[0] = ID_QUICK;  res.word[0] = pr(b[4], b[5]);
          res.id[1] = ID_NORMAL; res.word[1] = pr(b[6], b[7]);
          res.cnt = 3'd2; res.more = 1'b1;
        end else if (s == SEQ_21) begin
          res.id[0] = ID_FULL;    res.word[0] = pr(b[0], b[1]);
          res.id[1] = ID_PARTIAL; res.word[1] = pr(b[2], b[3]);
          res.cnt = 3'd2; res.more = 1'b1;
        end
      end
      DID_03: begin
        if (s == PCI_FIRST || (s >= SEQ_23 && s <= SEQ_26)) begin
          res.more = 1'b1;
        end else if (s == SEQ_21) begin
          hc_nxt = {b[7], 8'h0};
          res.id[0] = ID_TEMP;    res.word[0] = pr(b[1], b[2]);
          res.id[1] = ID_HIGH_MV; res.word[1] = {16'h0, hc_nxt};
          res.cnt = 3'd2; res.more = 1'b1;
        end else if (s == SEQ_22) begin
          hc_nxt = hc_r + {8'h0, b[1]};
          res.id[0] = ID_HIGH_MV; res.word[0] = {16'h0, hc_nxt};
          res.id[1] = ID_LOW_MV;  res.word[1] = pr(b[2], b[3]);
          res.cnt = 3'd2; res.more = 1'b1;
        end else if (s == SEQ_27) begin
          res.id[0] = ID_MAX_CHG; res.word[0] = pr(b[1], b[2]);
          res.cnt = 3'd1;
        end
      end
      DID_01: begin
        if (s == PCI_FIRST || s == SEQ_22 || (s >= SEQ_24 && s <= SEQ_26)) begin
          res.more = 1'b1;
        end else if (s == SEQ_21) begin
          res.id[0] = ID_CURRENT; res.word[0] = {b[3], b[4], b[5], b[6]};
          res.cnt = 3'd1; res.more = 1'b1;
        end else if (s == SEQ_23) begin
          res.id[0] = ID_MAX_IN;  res.word[0] = pr(b[3], b[4]);
          res.id[1] = ID_MAX_OUT; res.word[1] = pr(b[5], b[6]);
          res.cnt = 3'd2; res.more = 1'b1;
        end
      end
      default: res.more = 1'b0;
    endcase
    // A frame that writes nothing gives one empty result
    res.valid = (res.cnt != 3'd0);
    if (res.cnt == 3'd0) begin
      res.cnt = 3'd1;
      res.id[0] = 7'd0;
      res.word[0] = 32'h0;
    end
  end

  // Commit state when the frame is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      aid_r  <= '0;
      wrap_r <= 1'b0;
      odo_r  <= '0;
      hc_r   <= '0;
      for (int i = 0; i < ACC_SLOTS; i++) acc_r[i] <= '0;
    end else if (take) begin
      aid_r  <= aid_nxt;
      wrap_r <= wrap_nxt;
      odo_r  <= odo_nxt;
      hc_r   <= hc_nxt;
      if (acc_we) acc_r[slot] <= acc_wdata;
    end
  end

endmodule

FILE: src/bird_obuf.sv
// Result buffer: holds the results of one frame and sends them one per cycle while ready is high.
// Depends on bird_pkg.
module bird_obuf (
  input  logic               clk,
  input  logic               rst_n,
  input  bird_pkg::res_set_t res,
  input  logic               load,
  output logic               free,
  output logic [6:0]         value_id,
  output logic [31:0]        value_word,
  output logic               value_valid,
  output logic               last_of_frame,
  output logic               more_expected,
  output logic               busy,
  input  logic               ready
);
  import bird_pkg::*;

  res_set_t   set_r;
  logic       busy_r;
  logic [1:0] idx_r;
  logic       last;

  assign last          = ({1'b0, idx_r} == set_r.cnt - 3'd1);
  assign free          = !busy_r || (ready && last);
  assign busy          = busy_r;
  assign value_id      = set_r.id[idx_r];
  assign value_word    = set_r.word[idx_r];
  assign value_valid   = set_r.valid;
  assign last_of_frame = last;
  assign more_expected = set_r.more;

  // Load a new frame's results or advance on each transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else if (load) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
    end else if (busy_r && ready) begin
      if (last) busy_r <= 1'b0;
      idx_r <= idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) set_r <= res;
  end

endmodule

FILE: src/battery_isotp_response_decoder_unit.sv
// Top level of the battery diagnostic response decoder: input register,
// frame decoder and result buffer. Depends on bird_pkg, bird_dec, bird_obuf.
//
// Takes one 8-byte frame of a segmented diagnostic response per input
// transfer and gives one to four results, one per cycle on the output
// while out_tready is high. A frame is decoded from the input register and
// taken into the result buffer once the buffer is free; the next frame waits
// in the input register while the result buffer drains. There is no clearing
// pass: the control and decoder state reset together; data registers do not.
module battery_isotp_response_decoder_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // byte0..byte7, 8 bits each
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // value_id[6:0], value_word[38:7], more_expected[39]
  output logic        out_tuser,  // value_valid
  output logic        out_tlast   // last_of_frame
);
  import bird_pkg::*;

  logic        in_valid_r;
  logic [63:0] in_data_r;
  logic        take, free;
  res_set_t    res;
  logic [6:0]  vid;
  logic [31:0] vword;
  logic        more;

  assign take      = in_valid_r && free;
  assign in_tready = !in_valid_r || take;

  // Hold the incoming frame until the decoder takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) in_data_r <= in_tdata;
  end

  bird_dec u_dec (
    .clk   (clk),
    .rst_n (rst_n),
    .frame (in_data_r),
    .take  (take),
    .res   (res)
  );

  bird_obuf u_obuf (
    .clk           (clk),
    .rst_n         (rst_n),
    .res           (res),
    .load          (take),
    .free          (free),
    .value_id      (vid),
    .value_word    (vword),
    .value_valid   (out_tuser),
    .last_of_frame (out_tlast),
    .more_expected (more),
    .busy          (out_tvalid),
    .ready         (out_tready)
  );

  assign out_tdata = {more, vword, vid};

endmodule

FILE: tb/tb_battery_isotp_response_decoder_checker.sv
// Checker for the battery diagnostic response decoder: watches both stream
// channels, predicts the results of every accepted frame and compares them.
// Depends on bird_pkg for constants and value ids.
module tb_battery_isotp_response_decoder_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [63:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,
  input  logic        out_tuser,
  input  logic        out_tlast,
  output int          fail_count,
  output int          pending_count
);
  import bird_pkg::*;

  typedef struct packed {
    logic [6:0]  id;
    logic [31:0] word;
    logic        vld;
    logic        last;
    logic        more;
  } dec_result_t;

  dec_result_t result_q[$];

  logic [7:0]  active_did;
  logic        wrapped;
  logic [15:0] cells [CELL_COUNT];
  logic [31:0] km_acc;
  logic [15:0] high_mv_acc;

  // Frame under decode and results built for it
  logic [7:0]  fr [8];
  dec_result_t frame_res [4];
  int          nres;

  assign pending_count = result_q.size();

  function automatic logic [31:0] be16(int hi, int lo);
    return {16'h0, fr[hi], fr[lo]};
  endfunction

  function automatic logic [31:0] be32(int a);
    return {fr[a], fr[a+1], fr[a+2], fr[a+3]};
  endfunction

  task automatic push_value(int id, logic [31:0] val);
    if (nres < 4) begin
      frame_res[nres] = '{id: id[6:0], word: val, vld: 1'b1, last: 1'b0, more: 1'b0};
      nres++;
    end
  endtask

  task automatic write_cell(int i, logic [31:0] v);
    if (i < CELL_COUNT) begin
      cells[i] = v[15:0];
      push_value(i, {16'h0, cells[i]});
    end
  endtask

  task automatic add_to_cell(int i);
    if (i < CELL_COUNT) begin
      cells[i] = cells[i] + {8'h0, fr[1]};
      push_value(i, {16'h0, cells[i]});
    end
  endtask

  // Odd steps close a split cell, even steps open a group
  task automatic cell_group(int k, int open_base, int close_base);
    int p;
    p = k / 2;
    if (k % 2 == 0) begin
      write_cell(open_base + 7 * p, be16(1, 2));
      write_cell(open_base + 7 * p + 1, be16(3, 4));
      write_cell(open_base + 7 * p + 2, be16(5, 6));
      write_cell(open_base + 7 * p + 3, {16'h0, fr[7], 8'h0});
    end else begin
      add_to_cell(close_base + 7 * p);
      write_cell(close_base + 7 * p + 1, be16(2, 3));
      write_cell(close_base + 7 * p + 2, be16(4, 5));
      write_cell(close_base + 7 * p + 3, be16(6, 7));
    end
  endtask

  task automatic predict_frame(logic [63:0] data);
    logic [7:0] s;
    logic       more;
    for (int i = 0; i < 8; i++) fr[i] = data[8*i +: 8];
    s = fr[0];
    nres = 0;
    more = 1'b0;
    if (s == PCI_FIRST && fr[2] == SID_RESP) active_did = fr[3];
    case (active_did)
      DID_01: begin
        if (s == PCI_FIRST || s == SEQ_22 || (s >= SEQ_24 && s <= SEQ_26)) more = 1'b1;
        else if (s == SEQ_21) begin
          push_value(ID_CURRENT, be32(3)); more = 1'b1;
        end else if (s == SEQ_23) begin
          push_value(ID_MAX_IN, be16(3, 4)); push_value(ID_MAX_OUT, be16(5, 6));
          more = 1'b1;
        end
      end
      DID_61: begin
        if (s == PCI_FIRST) more = 1'b1;
        else if (s == SEQ_21) begin
          push_value(ID_AMP_HOURS, be32(1));
          push_value(ID_HEALTH, {24'h0, fr[5]});
          km_acc = {fr[6], fr[7], 16'h0};
          push_value(ID_KM, km_acc);
          more = 1'b1;
        end else if (s == SEQ_22) begin
          km_acc = km_acc + {24'h0, fr[1]};
          push_value(ID_KM, km_acc);
        end
      end
      DID_66: begin
        if (s == PCI_FIRST) begin
          push_value(ID_QUICK, be16(4, 5)); push_value(ID_NORMAL, be16(6, 7));
          more = 1'b1;
        end else if (s == SEQ_21) begin
          push_value(ID_FULL, be16(0, 1)); push_value(ID_PARTIAL, be16(2, 3));
          more = 1'b1;
        end
      end
      DID_03: begin
        if (s == PCI_FIRST || (s >= SEQ_23 && s <= SEQ_26)) more = 1'b1;
        else if (s == SEQ_21) begin
          push_value(ID_TEMP, be16(1, 2));
          high_mv_acc = {fr[7], 8'h0};
          push_value(ID_HIGH_MV, {16'h0, high_mv_acc});
          more = 1'b1;
        end else if (s == SEQ_22) begin
          high_mv_acc = high_mv_acc + {8'h0, fr[1]};
          push_value(ID_HIGH_MV, {16'h0, high_mv_acc});
          push_value(ID_LOW_MV, be16(2, 3));
          more = 1'b1;
        end else if (s == SEQ_27) begin
          push_value(ID_MAX_CHG, be16(1, 2));
        end
      end
      DID_41: begin
        if (s == PCI_FIRST) begin
          wrapped = 1'b0;
          write_cell(0, be16(4, 5)); write_cell(1, be16(6, 7));
          more = 1'b1;
        end else if (!wrapped && (s == SEQ_21 || s == SEQ_22)) begin
          cell_group(s - SEQ_21, 2, 5); more = 1'b1;
        end else if (s >= SEQ_23 && s <= SEQ_2F) begin
          cell_group(s - SEQ_21, 2, 5); more = 1'b1;
        end else if (s == SEQ_WRAP) begin
          wrapped = 1'b1; cell_group(15, 2, 5); more = 1'b1;
        end else if (wrapped && s == SEQ_21) begin
          cell_group(16, 2, 5); more = 1'b1;
        end else if (wrapped && s == SEQ_22) begin
          wrapped = 1'b0; add_to_cell(61);
        end
      end
      DID_42: begin
        if (s == PCI_FIRST) begin
          write_cell(62, be16(4, 5)); write_cell(63, be16(6, 7));
          more = 1'b1;
        end else if (s >= SEQ_21 && s <= SEQ_29) begin
          cell_group(s - SEQ_21, 64, 67); more = 1'b1;
        end else if (s == SEQ_2A) begin
          add_to_cell(95);
          push_value(ID_PACK_V, be16(2, 3)); push_value(ID_DIAG_V, be16(4, 5));
        end
      end
      default: more = 1'b0;
    endcase
    // Frames that write nothing still give one empty result
    if (nres == 0) begin
      frame_res[0] = '0;
      nres = 1;
    end
    for (int k = 0; k < nres; k++) begin
      frame_res[k].more = more;
      frame_res[k].last = (k == nres - 1);
      result_q.push_back(frame_res[k]);
    end
  endtask

  task automatic report_mismatch(string what, logic [39:0] got, logic [39:0] want);
    $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
  end

  // Predict on input transfers, compare on output transfers
  always @(posedge clk) begin
    dec_result_t want;
    if (!rst_n) begin
      active_did  <= '0;
      wrapped     <= 1'b0;
      km_acc      <= '0;
      high_mv_acc <= '0;
      for (int i = 0; i < CELL_COUNT; i++) cells[i] <= '0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (result_q.size() == 0) begin
          report_mismatch("unexpected result", out_tdata, '0);
        end else begin
          want = result_q.pop_front();
          if (out_tdata[6:0] != want.id) report_mismatch("value_id", out_tdata[6:0], want.id);
          if (out_tdata[38:7] != want.word)
            report_mismatch("value_word", out_tdata[38:7], want.word);
          if (out_tdata[39] != want.more)
            report_mismatch("more_expected", out_tdata[39], want.more);
          if (out_tuser != want.vld) report_mismatch("value_valid", out_tuser, want.vld);
          if (out_tlast != want.last) report_mismatch("last_of_frame", out_tlast, want.last);
        end
      end
      if (in_tvalid && in_tready) predict_frame(in_tdata);
    end
  end

endmodule

FILE: tb/tb_battery_isotp_response_decoder_unit.sv
// Testbench top for the battery diagnostic response decoder: drives frames
// with random gaps and output stalls, gives the verdict from the checker.
// Depends on bird_pkg, the block and tb_battery_isotp_response_decoder_checker.
module tb_battery_isotp_response_decoder_unit;
  import bird_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;
  int          fail_count;
  int          pending_count;
  int          cycle_count;
  int          frames_sent;
  bit          calm_mode;

  battery_isotp_response_decoder_unit dut (.*);

  tb_battery_isotp_response_decoder_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // End the run if it hangs
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("[battery_isotp_response_decoder_unit] ERROR");
        $finish;
      end
    end
  end

  // Stall the result side at random, with calm stretches
  initial begin
    int wait_cycles;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      wait_cycles = calm_mode ? 0 : $urandom_range(0, 16);
      if (wait_cycles > 0) begin
        out_tready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!(out_tvalid && out_tready)) @(posedge clk);
    end
  end

  task automatic send_frame(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2, logic [7:0] b3,
                            logic [7:0] b4, logic [7:0] b5, logic [7:0] b6, logic [7:0] b7);
    int gap;
    gap = calm_mode ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {b7, b6, b5, b4, b3, b2, b1, b0};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    frames_sent++;
  endtask

  function automatic logic [7:0] rb();
    return 8'($urandom_range(0, 255));
  endfunction

  // Response: first frame then consecutive frames with random payload; about one in sixteen sequence bytes is random
  task automatic send_sequence(logic [7:0] did);
    logic [7:0] seqs [$];
    send_frame(PCI_FIRST, rb(), SID_RESP, did, rb(), rb(), rb(), rb());
    case (did)
      DID_41: begin
        for (int s = 'h21; s <= 'h2F; s++) seqs.push_back(8'(s));
        seqs.push_back(SEQ_WRAP); seqs.push_back(SEQ_21); seqs.push_back(SEQ_22);
      end
      DID_42: for (int s = 'h21; s <= 'h2A; s++) seqs.push_back(8'(s));
      DID_03: for (int s = 'h21; s <= 'h27; s++) seqs.push_back(8'(s));
      DID_01: for (int s = 'h21; s <= 'h26; s++) seqs.push_back(8'(s));
      DID_61: begin seqs.push_back(SEQ_21); seqs.push_back(SEQ_22); end
      DID_66: seqs.push_back(SEQ_21);
      default: seqs.push_back(SEQ_21);
    endcase
    foreach (seqs[i])
      send_frame(($urandom_range(0, 15) == 0) ? rb() : seqs[i], rb(), rb(), rb(),
                 rb(), rb(), rb(), rb());
  endtask

  initial begin
    logic [7:0] dids [7];
    dids = '{DID_01, DID_03, DID_41, DID_42, DID_61, DID_66, 8'h55};
    frames_sent = 0;
    calm_mode = 1'b0;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: no identifier after reset, field extremes, every identifier
    send_frame(8'h21, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_frame(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_frame(PCI_FIRST, 8'hFF, SID_RESP, DID_61, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_frame(SEQ_21, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_frame(SEQ_22, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    // First frame without the response service keeps the identifier
    send_frame(PCI_FIRST, 8'h00, 8'h62, DID_66, 8'h12, 8'h34, 8'h56, 8'h78);
    send_frame(PCI_FIRST, 8'h00, SID_RESP, DID_66, 8'h12, 8'h34, 8'h56, 8'h78);
    send_frame(SEQ_21, 8'hA5, 8'h5A, 8'hC3, 8'h3C, 8'h00, 8'h00, 8'h00);
    send_frame(SEQ_27, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    calm_mode = 1'b1;
    send_frame(PCI_FIRST, 8'h00, SID_RESP, DID_03, 8'h00, 8'h00, 8'h00, 8'h00);
    send_frame(SEQ_21, 8'h01, 8'h02, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF);
    send_frame(SEQ_22, 8'hFF, 8'h11, 8'h22, 8'h00, 8'h00, 8'h00, 8'h00);
    send_frame(SEQ_27, 8'h33, 8'h44, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    calm_mode = 1'b0;
    send_frame(PCI_FIRST, 8'h00, SID_RESP, DID_01, 8'h00, 8'h00, 8'h00, 8'h00);
    send_frame(SEQ_21, 8'h00, 8'h00, 8'h80, 8'h00, 8'h00, 8'h01, 8'h00);
    send_frame(SEQ_23, 8'h00, 8'h00, 8'h7F, 8'hFF, 8'h80, 8'h00, 8'h00);
    send_frame(PCI_FIRST, 8'h00, SID_RESP, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_frame(SEQ_21, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_sequence(DID_41);
    send_sequence(DID_42);

    // Random: mostly well-formed responses, some noise frames
    while (frames_sent < 260) begin
      calm_mode = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 5) == 0) begin
        send_frame(rb(), rb(), rb(), rb(), rb(), rb(), rb(), rb());
      end else begin
        send_sequence(dids[$urandom_range(0, 6)]);
      end
    end
    in_tvalid <= 1'b0;
    calm_mode = 1'b0;

    while (pending_count != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending_count == 0)
      $display("[battery_isotp_response_decoder_unit] OK");
    else
      $display("[battery_isotp_response_decoder_unit] ERROR");
    $finish;
  end

endmodule
